>>> sv/chunk_reassembly_tracker_core_assert.svh
// Assertion macros for the chunk reassembly tracker datapath (crt_dp).
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CHUNK_REASSEMBLY_TRACKER_CORE_ASSERT_SVH
`define CHUNK_REASSEMBLY_TRACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/crt_pkg.sv
// Package for the chunk reassembly tracker: item structs, codes, reset values
// and the command and status structs between controller and datapath.
// Depends on nothing.
package crt_pkg;

  localparam int unsigned MaxChunksDefault = 64;
  localparam int unsigned TimerBitsDefault = 16;

  localparam logic [6:0]  ChunkCountReset   = 7'd1;
  localparam logic [15:0] BlockSizeReset    = 16'd1024;
  localparam logic [31:0] FrameIdReset      = 32'd0;
  localparam logic [15:0] InitTimeoutReset  = 16'd20;
  localparam logic [15:0] DropTimeoutReset  = 16'd100;
  localparam logic [15:0] ResendPeriodReset = 16'd20;

  localparam logic [2:0] CfgChunkCount   = 3'd0;
  localparam logic [2:0] CfgBlockSize    = 3'd1;
  localparam logic [2:0] CfgFrameId      = 3'd2;
  localparam logic [2:0] CfgInitTimeout  = 3'd3;
  localparam logic [2:0] CfgDropTimeout  = 3'd4;
  localparam logic [2:0] CfgResendPeriod = 3'd5;

  localparam logic ActChunk = 1'b0;
  localparam logic ActTick  = 1'b1;

  localparam logic [1:0] KindPlace    = 2'd0;
  localparam logic [1:0] KindRequest  = 2'd1;
  localparam logic [1:0] KindComplete = 2'd2;
  localparam logic [1:0] KindDropped  = 2'd3;

  typedef enum logic [1:0] {
    StAssembling = 2'd0,
    StReady      = 2'd1,
    StDropped    = 2'd2
  } status_e;

  typedef struct packed {
    logic        action;
    logic [5:0]  chunk_num;
    logic [15:0] chunk_length;
    logic [31:0] frame_bytes;
    logic        is_resend;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot_index;
    logic [21:0] write_offset;
    logic [15:0] write_length;
    logic [31:0] result_frame;
    logic [6:0]  request_total;
    logic [31:0] assembled_bytes;
    logic        last;
  } out_t;

  typedef struct packed {
    logic in_load;
    logic do_place;
    logic do_complete;
    logic do_tick;
    logic walk_clear;
    logic walk_next;
    logic walk_emit;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic finished;
    logic idx_ok;
    logic all_done;
    logic drop_x;
    logic round_x;
    logic out_free;
    logic walk_end;
    logic walk_hit;
  } sts_t;

endpackage

>>> sv/crt_ctrl.sv
// Controller of the chunk reassembly tracker: sequences each item through
// evaluation, completion and the resend walk. Depends on crt_pkg.
module crt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crt_pkg::sts_t sts_i,
  output crt_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    SIdle,
    SEval,
    SWalk,
    SComplete
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = crt_pkg::cmd_t'('0);
    cmd_o.in_load = in_valid_i && in_ready_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SEval;
        end
      end
      SEval: begin
        if (sts_i.finished) begin
          state_d = SIdle;
        end else if (sts_i.action == crt_pkg::ActChunk) begin
          if (!sts_i.idx_ok) begin
            state_d = SIdle;
          end else if (sts_i.out_free) begin
            cmd_o.do_place = 1'b1;
            state_d = sts_i.all_done ? SComplete : SIdle;
          end
        end else if (sts_i.drop_x) begin
          if (sts_i.out_free) begin
            cmd_o.do_tick = 1'b1;
            state_d = SIdle;
          end
        end else begin
          cmd_o.do_tick = 1'b1;
          if (sts_i.round_x) begin
            cmd_o.walk_clear = 1'b1;
            state_d = SWalk;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SWalk: begin
        if (sts_i.walk_end) begin
          state_d = SIdle;
        end else if (!sts_i.walk_hit) begin
          cmd_o.walk_next = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.walk_emit = 1'b1;
          cmd_o.walk_next = 1'b1;
        end
      end
      SComplete: begin
        if (sts_i.out_free) begin
          cmd_o.do_complete = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == SIdle);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

>>> sv/crt_dp.sv
// Datapath of the chunk reassembly tracker: configuration registers, the
// received map, the three timers and the output register.
// Depends on crt_pkg and chunk_reassembly_tracker_core_assert.svh.
`include "chunk_reassembly_tracker_core_assert.svh"

module crt_dp #(
  parameter int unsigned MaxChunks = crt_pkg::MaxChunksDefault,
  parameter int unsigned TimerBits = crt_pkg::TimerBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  crt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crt_pkg::out_t out_data_o,
  input  crt_pkg::cmd_t cmd_i,
  output crt_pkg::sts_t sts_o
);

  localparam int unsigned PtrW = $clog2(MaxChunks + 1);
  localparam int unsigned IdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;

  typedef struct packed {
    logic                 active;
    logic [TimerBits-1:0] count;
  } tmr_t;

  function automatic tmr_t tmr_load(logic [15:0] ticks);
    tmr_t                 r;
    logic [TimerBits-1:0] c;
    c        = TimerBits'(ticks);
    r.active = 1'b1;
    r.count  = (c == '0) ? TimerBits'(1) : c;
    return r;
  endfunction

  function automatic logic tmr_expires(tmr_t t);
    return t.active && (t.count <= TimerBits'(1));
  endfunction

  function automatic tmr_t tmr_advance(tmr_t t);
    tmr_t r;
    r = t;
    if (tmr_expires(t)) begin
      r = tmr_t'('0);
    end else if (t.active) begin
      r.count = t.count - TimerBits'(1);
    end
    return r;
  endfunction

  logic [6:0]  chunk_count_q;
  logic [15:0] block_size_q;
  logic [31:0] frame_id_q;
  logic [15:0] init_timeout_q;
  logic [15:0] drop_timeout_q;
  logic [15:0] resend_period_q;

  logic [MaxChunks-1:0] map_q;
  crt_pkg::status_e     status_q;
  logic                 resend_mode_q;
  tmr_t                 init_q, drop_q, resend_q;
  logic [PtrW-1:0]      ptr_q;
  crt_pkg::in_t         in_q;
  logic                 out_valid_q;
  crt_pkg::out_t        out_q, out_d;

  logic [PtrW-1:0]      eff_n;
  logic [MaxChunks-1:0] mask_n, upto_ptr, idx_bit, map_set;
  logic                 init_x, drop_x, resend_x, round_x;
  logic                 idx_ok, all_done, rest_full, out_free, out_load;

  always_comb begin
    if (chunk_count_q == 7'd0) begin
      eff_n = PtrW'(1);
    end else if (chunk_count_q > 7'(MaxChunks)) begin
      eff_n = PtrW'(MaxChunks);
    end else begin
      eff_n = PtrW'(chunk_count_q);
    end
  end

  always_comb begin
    for (int j = 0; j < MaxChunks; j++) begin
      mask_n[j]   = PtrW'(j) < eff_n;
      upto_ptr[j] = PtrW'(j) <= ptr_q;
      idx_bit[j]  = (PtrW'(j) == PtrW'(in_q.chunk_num));
    end
  end

  assign map_set   = map_q | idx_bit;
  assign idx_ok    = 7'(in_q.chunk_num) < 7'(eff_n);
  assign all_done  = &(map_set | ~mask_n);
  assign rest_full = &(map_q | ~mask_n | upto_ptr);

  assign init_x   = tmr_expires(init_q);
  assign drop_x   = tmr_expires(drop_q);
  assign resend_x = tmr_expires(resend_q);
  assign round_x  = init_x || (resend_x && resend_mode_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.do_place || cmd_i.do_complete || cmd_i.walk_emit ||
                    (cmd_i.do_tick && drop_x);

  always_comb begin
    sts_o          = crt_pkg::sts_t'('0);
    sts_o.action   = in_q.action;
    sts_o.finished = (status_q != crt_pkg::StAssembling);
    sts_o.idx_ok   = idx_ok;
    sts_o.all_done = all_done;
    sts_o.drop_x   = drop_x;
    sts_o.round_x  = round_x;
    sts_o.out_free = out_free;
    sts_o.walk_end = ptr_q >= eff_n;
    sts_o.walk_hit = !map_q[ptr_q[IdxW-1:0]];
  end

  always_comb begin
    out_d              = crt_pkg::out_t'('0);
    out_d.result_frame = frame_id_q;
    if (cmd_i.do_place) begin
      out_d.kind         = crt_pkg::KindPlace;
      out_d.slot_index   = in_q.chunk_num;
      out_d.write_offset = 22'(in_q.chunk_num) * 22'(block_size_q);
      out_d.write_length = in_q.chunk_length;
      out_d.last         = !all_done;
    end else if (cmd_i.do_complete) begin
      out_d.kind            = crt_pkg::KindComplete;
      out_d.assembled_bytes = in_q.frame_bytes;
      out_d.last            = 1'b1;
    end else if (cmd_i.walk_emit) begin
      out_d.kind          = crt_pkg::KindRequest;
      out_d.slot_index    = 6'(ptr_q);
      out_d.request_total = 7'(eff_n);
      out_d.last          = rest_full;
    end else begin
      out_d.kind = crt_pkg::KindDropped;
      out_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_count_q   <= crt_pkg::ChunkCountReset;
      block_size_q    <= crt_pkg::BlockSizeReset;
      frame_id_q      <= crt_pkg::FrameIdReset;
      init_timeout_q  <= crt_pkg::InitTimeoutReset;
      drop_timeout_q  <= crt_pkg::DropTimeoutReset;
      resend_period_q <= crt_pkg::ResendPeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crt_pkg::CfgChunkCount:   chunk_count_q   <= cfg_data_i[6:0];
        crt_pkg::CfgBlockSize:    block_size_q    <= cfg_data_i[15:0];
        crt_pkg::CfgFrameId:      frame_id_q      <= cfg_data_i;
        crt_pkg::CfgInitTimeout:  init_timeout_q  <= cfg_data_i[15:0];
        crt_pkg::CfgDropTimeout:  drop_timeout_q  <= cfg_data_i[15:0];
        crt_pkg::CfgResendPeriod: resend_period_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q         <= '0;
      status_q      <= crt_pkg::StAssembling;
      resend_mode_q <= 1'b0;
      init_q        <= tmr_t'('0);
      drop_q        <= tmr_t'('0);
      resend_q      <= tmr_t'('0);
      ptr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.do_place) begin
        map_q <= map_set;
        if (all_done) begin
          status_q      <= crt_pkg::StReady;
          resend_mode_q <= 1'b0;
          init_q        <= tmr_t'('0);
          drop_q        <= tmr_t'('0);
          resend_q      <= tmr_t'('0);
        end else if (!in_q.is_resend && !resend_mode_q) begin
          init_q <= tmr_load(init_timeout_q);
        end
      end else if (cmd_i.do_tick) begin
        if (drop_x) begin
          resend_mode_q <= 1'b0;
          status_q      <= crt_pkg::StDropped;
          init_q        <= tmr_t'('0);
          drop_q        <= tmr_t'('0);
          resend_q      <= tmr_t'('0);
        end else begin
          init_q <= tmr_advance(init_q);
          if (init_x && !resend_mode_q) begin
            resend_mode_q <= 1'b1;
            drop_q        <= tmr_load(drop_timeout_q);
          end else begin
            drop_q <= tmr_advance(drop_q);
          end
          resend_q <= round_x ? tmr_load(resend_period_q) : tmr_advance(resend_q);
        end
      end
      if (cmd_i.walk_clear) begin
        ptr_q <= '0;
      end else if (cmd_i.walk_next) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CRT_ASSERT_IMPL(a_load_when_free, out_load, out_free, "Result loaded over an untaken result.")
  `CRT_ASSERT_NEXT(a_status_final, sts_o.finished, $stable(status_q), "Finished status changed.")
  `CRT_ASSERT_IMPL(a_resend_assembling, resend_mode_q, !sts_o.finished, "Resend mode when done.")
  `CRT_ASSERT_IMPL(a_drop_in_resend, drop_q.active, resend_mode_q, "Drop timer outside resend mode.")

endmodule

>>> sv/chunk_reassembly_tracker_core.sv
// Top level of the chunk reassembly tracker: joins controller and datapath.
// Depends on crt_pkg, crt_ctrl and crt_dp.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i (crt_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (crt_pkg::out_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each item is evaluated; a chunk that fills the last slot then also completes the frame.
// A tick that starts a resend round then walks every slot below the chunk count.
// The controller holds one item at a time; results leave through one output register.
// A stalled output pauses placement, completion, drop and the walk until it is taken.
// Reset clears the received map, status and timers at once; no clearing pass.
module chunk_reassembly_tracker_core #(
  parameter int unsigned MaxChunks = crt_pkg::MaxChunksDefault,
  parameter int unsigned TimerBits = crt_pkg::TimerBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crt_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  crt_pkg::cmd_t cmd;
  crt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  crt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crt_dp #(
    .MaxChunks (MaxChunks),
    .TimerBits (TimerBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> sim/chunk_reassembly_tracker_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for chunk_reassembly_tracker_core: a queue-fed driver, a checking
// monitor and an in-bench prediction of placement, resend, completion and drop items.
// Depends on crt_pkg and the chunk_reassembly_tracker_core RTL.
module chunk_reassembly_tracker_core_tb;

  localparam int unsigned MaxChunks      = crt_pkg::MaxChunksDefault;
  localparam int unsigned TimerBits      = crt_pkg::TimerBitsDefault;
  localparam int unsigned ClkPeriod      = 10;
  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned SettleCycles   = 80;
  localparam int unsigned RandomItems    = 300;
  localparam int unsigned BatchItems     = 25;
  localparam int unsigned HoldAfterItems = 60;
  localparam int unsigned HoldCycles     = 600;
  localparam int unsigned LimitCycles    = 1000000;
  localparam logic [2:0]  CfgSpare       = 3'd7;
  localparam int          TmInit         = 0;
  localparam int          TmDrop         = 1;
  localparam int          TmRound        = 2;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  crt_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  crt_pkg::out_t out_data_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i  = '0;

  chunk_reassembly_tracker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  logic [6:0]           cfg_chunk_count;
  logic [15:0]          cfg_block_size;
  logic [31:0]          cfg_frame_id;
  logic [15:0]          cfg_init_timeout;
  logic [15:0]          cfg_drop_timeout;
  logic [15:0]          cfg_resend_period;
  logic [MaxChunks-1:0] have_map;
  crt_pkg::status_e     frame_state;
  logic                 resend_on;
  logic                 timer_run [3];
  longint unsigned      timer_left [3];

  crt_pkg::out_t results_due [$];
  crt_pkg::in_t  items_to_send [$];
  int unsigned   mismatches     = 0;
  int unsigned   accepted_items = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   gap_left       = 0;
  int unsigned   burst_left     = 0;
  int unsigned   pattern_left   = 0;
  int unsigned   stall_pct      = 0;
  int unsigned   hold_left      = 0;
  logic          hold_used      = 1'b0;

  function automatic void reset_model();
    cfg_chunk_count   = crt_pkg::ChunkCountReset;
    cfg_block_size    = crt_pkg::BlockSizeReset;
    cfg_frame_id      = crt_pkg::FrameIdReset;
    cfg_init_timeout  = crt_pkg::InitTimeoutReset;
    cfg_drop_timeout  = crt_pkg::DropTimeoutReset;
    cfg_resend_period = crt_pkg::ResendPeriodReset;
    have_map          = '0;
    frame_state       = crt_pkg::StAssembling;
    resend_on         = 1'b0;
    for (int i = 0; i < 3; i++) begin
      timer_run[i]  = 1'b0;
      timer_left[i] = 0;
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      crt_pkg::CfgChunkCount:   cfg_chunk_count   = data[6:0];
      crt_pkg::CfgBlockSize:    cfg_block_size    = data[15:0];
      crt_pkg::CfgFrameId:      cfg_frame_id      = data;
      crt_pkg::CfgInitTimeout:  cfg_init_timeout  = data[15:0];
      crt_pkg::CfgDropTimeout:  cfg_drop_timeout  = data[15:0];
      crt_pkg::CfgResendPeriod: cfg_resend_period = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned active_chunks();
    if (cfg_chunk_count == 0) return 1;
    if (cfg_chunk_count > MaxChunks) return MaxChunks;
    return cfg_chunk_count;
  endfunction

  // A load of zero still expires on the next tick.
  function automatic void arm_timer(int id, logic [15:0] ticks);
    longint unsigned load;
    load = longint'(ticks) & ((64'd1 << TimerBits) - 1);
    timer_run[id]  = 1'b1;
    timer_left[id] = (load == 0) ? 1 : load;
  endfunction

  function automatic void stop_timer(int id);
    timer_run[id]  = 1'b0;
    timer_left[id] = 0;
  endfunction

  function automatic logic tick_timer(int id);
    if (!timer_run[id]) return 1'b0;
    if (timer_left[id] <= 1) begin
      stop_timer(id);
      return 1'b1;
    end
    timer_left[id] = timer_left[id] - 1;
    return 1'b0;
  endfunction

  function automatic crt_pkg::out_t make_result(logic [1:0] kind, logic [5:0] slot,
                                                logic [21:0] offset, logic [15:0] length,
                                                logic [6:0] total, logic [31:0] bytes);
    crt_pkg::out_t r;
    r.kind            = kind;
    r.slot_index      = slot;
    r.write_offset    = offset;
    r.write_length    = length;
    r.result_frame    = cfg_frame_id;
    r.request_total   = total;
    r.assembled_bytes = bytes;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic void predict_results(crt_pkg::in_t it);
    int unsigned   n;
    int unsigned   base;
    logic          full;
    logic          init_x;
    logic          drop_x;
    logic          round_x;
    crt_pkg::out_t tail;
    if (frame_state != crt_pkg::StAssembling) return;
    n    = active_chunks();
    base = results_due.size();
    if (it.action == crt_pkg::ActChunk) begin
      if (it.chunk_num >= n) return;
      have_map[it.chunk_num] = 1'b1;
      results_due.push_back(make_result(crt_pkg::KindPlace, it.chunk_num,
                                        22'(it.chunk_num) * 22'(cfg_block_size),
                                        it.chunk_length, 7'd0, 32'd0));
      full = 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
        if (!have_map[i]) full = 1'b0;
      end
      if (full) begin
        frame_state = crt_pkg::StReady;
        resend_on   = 1'b0;
        stop_timer(TmInit);
        stop_timer(TmDrop);
        stop_timer(TmRound);
        results_due.push_back(make_result(crt_pkg::KindComplete, 6'd0, 22'd0, 16'd0, 7'd0,
                                          it.frame_bytes));
      end else if (!it.is_resend && !resend_on) begin
        arm_timer(TmInit, cfg_init_timeout);
      end
    end else begin
      init_x  = tick_timer(TmInit);
      drop_x  = tick_timer(TmDrop);
      round_x = tick_timer(TmRound);
      if (drop_x) begin
        resend_on   = 1'b0;
        frame_state = crt_pkg::StDropped;
        stop_timer(TmInit);
        stop_timer(TmRound);
        results_due.push_back(make_result(crt_pkg::KindDropped, 6'd0, 22'd0, 16'd0, 7'd0,
                                          32'd0));
      end else if (init_x || round_x) begin
        if (init_x && !resend_on) begin
          resend_on = 1'b1;
          arm_timer(TmDrop, cfg_drop_timeout);
        end
        if (resend_on) begin
          for (int unsigned i = 0; i < n; i++) begin
            if (!have_map[i]) begin
              results_due.push_back(make_result(crt_pkg::KindRequest, 6'(i), 22'd0, 16'd0,
                                                7'(n), 32'd0));
            end
          end
          arm_timer(TmRound, cfg_resend_period);
        end
      end
    end
    if (results_due.size() > base) begin
      tail      = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic void check_result(crt_pkg::out_t got);
    crt_pkg::out_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      $error("unexpected result item: kind %0d slot %0d", got.kind, got.slot_index);
      return;
    end
    want = results_due.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("slot_index", want.slot_index, got.slot_index);
    compare_field("write_offset", want.write_offset, got.write_offset);
    compare_field("write_length", want.write_length, got.write_length);
    compare_field("result_frame", want.result_frame, got.result_frame);
    compare_field("request_total", want.request_total, got.request_total);
    compare_field("assembled_bytes", want.assembled_bytes, got.assembled_bytes);
    compare_field("last", want.last, got.last);
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void add_chunk(logic [5:0] idx, logic [15:0] length, logic [31:0] bytes,
                                    logic resend);
    crt_pkg::in_t it;
    it.action       = crt_pkg::ActChunk;
    it.chunk_num    = idx;
    it.chunk_length = length;
    it.frame_bytes  = bytes;
    it.is_resend    = resend;
    items_to_send.push_back(it);
  endfunction

  function automatic void add_tick();
    crt_pkg::in_t it;
    it.action       = crt_pkg::ActTick;
    it.chunk_num    = 6'($urandom());
    it.chunk_length = 16'($urandom());
    it.frame_bytes  = $urandom();
    it.is_resend    = 1'($urandom_range(0, 1));
    items_to_send.push_back(it);
  endfunction

  // Withheld slots are never sent at random, so the frame cannot complete by chance.
  function automatic crt_pkg::in_t random_item(logic [MaxChunks-1:0] withheld);
    crt_pkg::in_t it;
    it.action = ($urandom_range(0, 99) < 45) ? crt_pkg::ActTick : crt_pkg::ActChunk;
    do begin
      it.chunk_num = 6'($urandom());
    end while (withheld[it.chunk_num]);
    it.chunk_length = pick_length();
    it.frame_bytes  = $urandom();
    it.is_resend    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    int unsigned width;
    logic [31:0] noise;
    case (idx) inside
      crt_pkg::CfgChunkCount:        width = 7;
      crt_pkg::CfgFrameId, CfgSpare: width = 32;
      default:                       width = 16;
    endcase
    noise = $urandom_range(0, 1) ? ($urandom() << width) : 32'd0;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value | noise;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, value | noise);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid_i || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reconfigure(logic drop_ending);
    int unsigned r;
    r = $urandom_range(0, 5);
    write_reg(crt_pkg::CfgChunkCount,
              (r == 0) ? 7'd127 : (r < 3) ? 7'd64 : 7'($urandom_range(2, 63)));
    r = $urandom_range(0, 7);
    write_reg(crt_pkg::CfgBlockSize, (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF :
                                     (r == 2) ? 16'd0 : 16'($urandom()));
    write_reg(crt_pkg::CfgFrameId, $urandom());
    write_reg(crt_pkg::CfgInitTimeout, 16'($urandom()));
    write_reg(crt_pkg::CfgDropTimeout, 16'($urandom()));
    if (!drop_ending) write_reg(crt_pkg::CfgResendPeriod, 16'($urandom_range(0, 8)));
    if ($urandom_range(0, 7) == 0) write_reg(CfgSpare, $urandom());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_results(in_data_i);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0 || items_to_send.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= items_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // One long hold-off on the output lets the block fill up and stall its input.
  always @(posedge clk_i) begin
    if (!hold_used && accepted_items >= HoldAfterItems) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0:       stall_pct <= 0;
          1:       stall_pct <= 30;
          default: stall_pct <= 70;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("FAIL chunk_reassembly_tracker_core");
      $finish;
    end
  end

  initial begin
    logic                 drop_ending;
    int unsigned          period;
    int unsigned          drop_ticks;
    int unsigned          useful;
    int unsigned          start;
    int unsigned          slot;
    logic [MaxChunks-1:0] withheld;
    crt_pkg::in_t         it;
    reset_model();
    // The frame ends once, by either completion or drop, so the run picks one of them.
    drop_ending = 1'($urandom_range(0, 1));
    period      = drop_ending ? $urandom_range(2, 6) : 3;
    drop_ticks  = drop_ending ? period * ((130 + period - 1) / period) : 65535;
    withheld    = '0;
    withheld[1] = 1'b1;
    while ($countones(withheld) < 4) withheld[$urandom_range(10, 62)] = 1'b1;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(crt_pkg::CfgChunkCount, 7'd127);
    write_reg(crt_pkg::CfgBlockSize, 16'hFFFF);
    write_reg(crt_pkg::CfgFrameId, 32'hFFFF_FFFF);
    write_reg(crt_pkg::CfgInitTimeout, 16'hFFFF);
    write_reg(crt_pkg::CfgDropTimeout, 16'd0);
    write_reg(crt_pkg::CfgResendPeriod, 16'hFFFF);
    write_reg(CfgSpare, $urandom());
    add_chunk(6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_chunk(6'd0, 16'd0, 32'd0, 1'b1);
    add_chunk(6'd63, pick_length(), $urandom(), 1'b0);
    add_tick();
    add_tick();
    wait_idle();

    write_reg(crt_pkg::CfgChunkCount, 7'd10);
    write_reg(crt_pkg::CfgBlockSize, 16'd1);
    write_reg(crt_pkg::CfgFrameId, 32'd0);
    add_chunk(6'd12, pick_length(), $urandom(), 1'b0);
    add_chunk(6'd9, pick_length(), $urandom(), 1'b0);
    add_tick();
    wait_idle();

    write_reg(crt_pkg::CfgChunkCount, 7'd0);
    add_chunk(6'd5, pick_length(), $urandom(), 1'b0);
    add_tick();
    wait_idle();

    // A resent chunk leaves the init timer alone; an initial one reloads it with zero, which
    // expires on the next tick and starts resend mode. The next round follows after the period.
    write_reg(crt_pkg::CfgChunkCount, 7'd64);
    write_reg(crt_pkg::CfgBlockSize, 16'($urandom()));
    write_reg(crt_pkg::CfgFrameId, $urandom());
    write_reg(crt_pkg::CfgInitTimeout, 16'd0);
    write_reg(crt_pkg::CfgDropTimeout, 16'(drop_ticks));
    write_reg(crt_pkg::CfgResendPeriod, 16'(period));
    add_chunk(6'd2, pick_length(), $urandom(), 1'b1);
    add_chunk(6'd3, pick_length(), $urandom(), 1'b0);
    add_tick();
    repeat (period) add_tick();
    wait_idle();

    useful = 0;
    while (useful < RandomItems && frame_state == crt_pkg::StAssembling) begin
      reconfigure(drop_ending);
      repeat (BatchItems) begin
        it = random_item(withheld);
        if (it.action == crt_pkg::ActTick || it.chunk_num < active_chunks()) useful++;
        items_to_send.push_back(it);
      end
      wait_idle();
    end

    if (drop_ending) begin
      while (frame_state == crt_pkg::StAssembling) begin
        repeat (8) add_tick();
        wait_idle();
      end
    end else if (frame_state == crt_pkg::StAssembling) begin
      write_reg(crt_pkg::CfgChunkCount, 7'd64);
      start = $urandom_range(0, MaxChunks - 1);
      for (int unsigned k = 0; k < MaxChunks; k++) begin
        slot = (start + k) % MaxChunks;
        if (!have_map[slot]) begin
          add_chunk(6'(slot), pick_length(), $urandom(), 1'($urandom_range(0, 1)));
        end
      end
      wait_idle();
    end

    // Once the frame has finished, nothing may come out any more.
    add_chunk(6'd0, pick_length(), $urandom(), 1'b0);
    add_chunk(6'd1, pick_length(), $urandom(), 1'b1);
    add_tick();
    add_tick();
    wait_idle();

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS chunk_reassembly_tracker_core");
    end else begin
      $display("FAIL chunk_reassembly_tracker_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/crt_pkg.sv
sv/crt_ctrl.sv
sv/crt_dp.sv
sv/chunk_reassembly_tracker_core.sv
sim/chunk_reassembly_tracker_core_tb.sv
